// File: hw/rtl/bpa_pkg.sv
package bpa_pkg;

    // geometry of the managed region
    localparam int NUM_PAGES   = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WORD_COUNT  = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PIDX_W      = WIDX_W + BIT_W;
    localparam int ADDR_W      = 32;

    // bytes covered by all pages, used for the upper range check on free
    localparam longint unsigned SPAN = longint'(NUM_PAGES) * longint'(PAGE_BYTES);

    // reset contents of bitmap word 0: first four pages reserved
    localparam logic [WORD_W-1:0] INIT_WORD0 = 32'h0000_000F;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

    // bits of the last word beyond the last page read as used
    localparam int LAST_BITS = NUM_PAGES % WORD_W;
    localparam logic [WORD_W-1:0] LAST_PAD =
        (LAST_BITS == 0) ? '0 : ~((32'h1 << LAST_BITS) - 32'h1);

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // bitmap port request
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [WIDX_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } bm_req_t;

endpackage

// File: hw/rtl/bitmap_page_allocator.sv
// first-fit page frame allocator over a used-page bitmap
//
// input channel s_*: one request word; s_tuser[0] is the request kind
// (0 allocate, 1 free), s_tdata holds the address to free (ignored on
// allocate). output channel m_*: one result word per request; m_tdata is
// the allocated page address (0 otherwise), m_tuser the status
// (0 done, 1 no free page, 2 free address out of range).
// cfg_we/cfg_wdata write the base address of page 0. the user must write
// it only while idle; the block itself does not enforce this.
// an allocate reads the bitmap one 32-page word per cycle from page 0 up
// through a single-port bitmap ram until it finds a clear bit, then marks
// the page used and forms its address. a free does the range check on the
// shared adder and reads the word, then writes the word back (an
// out-of-range free skips the read and write). s_tready returns the
// cycle after the result is loaded, so a new request is taken only once
// the last one is done.
// the result sits in an output register: a new request is accepted while
// it waits, but the next result is held until m_tready takes the old one.
// reset (aresetn low, synchronous) marks pages 0..3 used, all others free,
// and sets the base to 0x100000; no clearing pass is needed.
module bitmap_page_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] free_address
    input  logic [0:0]  s_tuser,   // [0] operation
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] page_address
    output logic [1:0]  m_tuser,   // [1:0] status
    // base address register
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [bpa_pkg::WIDX_W-1:0] LAST_WORD =
        bpa_pkg::WIDX_W'(bpa_pkg::WORD_COUNT - 1);

    logic [2:0]                         state_reg, state_next;
    logic [bpa_pkg::ADDR_W-1:0]         base_reg;
    logic [bpa_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic [bpa_pkg::WIDX_W-1:0]         idx_reg, idx_next;
    logic [bpa_pkg::BIT_W-1:0]          bit_reg, bit_next;
    logic [bpa_pkg::ADDR_W-1:0]         res_addr_reg, res_addr_next;
    logic [1:0]                         res_st_reg, res_st_next;
    logic                               m_tvalid_reg;
    logic [31:0]                        m_tdata_reg;
    logic [1:0]                         m_tuser_reg;

    bpa_pkg::bm_req_t                   bm_req;
    logic [bpa_pkg::WORD_W-1:0]         bm_rdata;
    logic [bpa_pkg::WORD_W-1:0]         scan_word;
    logic                               scan_hit;
    logic [bpa_pkg::BIT_W-1:0]          scan_bit;

    logic [bpa_pkg::ADDR_W-1:0]         alu_a, alu_b;
    logic                               alu_sub;
    logic [bpa_pkg::ADDR_W:0]           alu_sum;
    logic [bpa_pkg::ADDR_W-1:0]         page_off;
    logic [bpa_pkg::PIDX_W-1:0]         rel_page;
    logic                               out_of_range;
    logic                               s_accept;
    logic                               out_load;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    bpa_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bm_req),
        .rdata   (bm_rdata)
    );

    bpa_addsub u_addsub (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    // shared adder: base + page offset on allocate, address - base on free
    assign page_off = bpa_pkg::ADDR_W'({idx_reg, bit_reg}) << bpa_pkg::PAGE_SHIFT;

    always_comb begin
        if (state_reg == S_CHECK) begin
            alu_a   = addr_reg;
            alu_b   = base_reg;
            alu_sub = 1'b1;
        end else begin
            alu_a   = base_reg;
            alu_b   = page_off;
            alu_sub = 1'b0;
        end
    end

    // below base shows as no carry; past the last page as offset >= span
    assign out_of_range = !alu_sum[bpa_pkg::ADDR_W] ||
        ({1'b0, alu_sum[bpa_pkg::ADDR_W-1:0]} >= (bpa_pkg::ADDR_W + 1)'(bpa_pkg::SPAN));
    assign rel_page = alu_sum[bpa_pkg::PAGE_SHIFT +: bpa_pkg::PIDX_W];

    // pages past the end of the region count as used
    assign scan_word = (idx_reg == LAST_WORD) ? (bm_rdata | bpa_pkg::LAST_PAD) : bm_rdata;
    assign scan_hit  = (scan_word != '1);

    // lowest clear bit of the word under scan
    always_comb begin
        scan_bit = '0;
        for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (!scan_word[i]) begin
                scan_bit = bpa_pkg::BIT_W'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        bit_next      = bit_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        bm_req        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    addr_next = s_tdata;
                    if (s_tuser[0] == bpa_pkg::OP_ALLOC) begin
                        idx_next     = '0;
                        bm_req.rd_en = 1'b1;
                        bm_req.addr  = '0;
                        state_next   = S_SCAN;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    // mark the page used and go form its address
                    bit_next     = scan_bit;
                    bm_req.wr_en = 1'b1;
                    bm_req.addr  = idx_reg;
                    bm_req.wdata = bm_rdata | (bpa_pkg::WORD_W'(1) << scan_bit);
                    state_next   = S_ADDR;
                end else if (idx_reg == LAST_WORD) begin
                    res_addr_next = '0;
                    res_st_next   = bpa_pkg::ST_FULL;
                    state_next    = S_DONE;
                end else begin
                    idx_next     = idx_reg + 1'b1;
                    bm_req.rd_en = 1'b1;
                    bm_req.addr  = idx_reg + 1'b1;
                end
            end
            S_ADDR: begin
                res_addr_next = alu_sum[bpa_pkg::ADDR_W-1:0];
                res_st_next   = bpa_pkg::ST_DONE;
                state_next    = S_DONE;
            end
            S_CHECK: begin
                if (out_of_range) begin
                    res_addr_next = '0;
                    res_st_next   = bpa_pkg::ST_RANGE;
                    state_next    = S_DONE;
                end else begin
                    idx_next     = rel_page[bpa_pkg::PIDX_W-1 -: bpa_pkg::WIDX_W];
                    bit_next     = rel_page[bpa_pkg::BIT_W-1:0];
                    bm_req.rd_en = 1'b1;
                    bm_req.addr  = rel_page[bpa_pkg::PIDX_W-1 -: bpa_pkg::WIDX_W];
                    state_next   = S_CLEAR;
                end
            end
            S_CLEAR: begin
                bm_req.wr_en  = 1'b1;
                bm_req.addr   = idx_reg;
                bm_req.wdata  = bm_rdata & ~(bpa_pkg::WORD_W'(1) << bit_reg);
                res_addr_next = '0;
                res_st_next   = bpa_pkg::ST_DONE;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            base_reg     <= bpa_pkg::BASE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working and result payload, no reset needed
    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        idx_reg      <= idx_next;
        bit_reg      <= bit_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        if (out_load) begin
            m_tdata_reg <= res_addr_reg;
            m_tuser_reg <= res_st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a request leaves the sequencer busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("sequencer idle right after accepting a request");

    // the bitmap port never reads and writes in one cycle
    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(bm_req.rd_en && bm_req.wr_en))
        else $error("bitmap read and write in the same cycle");

    // only a successful allocate returns a nonzero address
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == bpa_pkg::ST_FULL || m_tuser == bpa_pkg::ST_RANGE))
        |-> (m_tdata == '0))
        else $error("nonzero address on a failed request");

    // result status is always a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == bpa_pkg::ST_DONE || m_tuser == bpa_pkg::ST_FULL ||
                      m_tuser == bpa_pkg::ST_RANGE))
        else $error("undefined result status");

endmodule

// File: hw/rtl/bpa_bitmap.sv
module bpa_bitmap (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpa_pkg::bm_req_t  req,
    output logic [bpa_pkg::WORD_W-1:0] rdata
);

    logic [bpa_pkg::WORD_W-1:0]     mem [bpa_pkg::WORD_COUNT];
    logic [bpa_pkg::WORD_COUNT-1:0] valid_reg;
    logic [bpa_pkg::WORD_W-1:0]     rd_word_reg;
    logic [bpa_pkg::WORD_W-1:0]     rd_init_reg;
    logic                           rd_valid_reg;

    // one port: write or registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_word_reg  <= mem[req.addr];
            rd_valid_reg <= valid_reg[req.addr];
            rd_init_reg  <= (req.addr == '0) ? bpa_pkg::INIT_WORD0 : '0;
        end
    end

    // words never written read as their reset contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    assign rdata = rd_valid_reg ? rd_word_reg : rd_init_reg;

endmodule

// File: hw/rtl/bpa_addsub.sv
module bpa_addsub (
    input  logic [bpa_pkg::ADDR_W-1:0] a,
    input  logic [bpa_pkg::ADDR_W-1:0] b,
    input  logic                       sub,
    output logic [bpa_pkg::ADDR_W:0]   sum
);

    logic [bpa_pkg::ADDR_W-1:0] b_op;

    // carry out of a subtract is set when a >= b
    assign b_op = sub ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + {{bpa_pkg::ADDR_W{1'b0}}, sub};

endmodule
